// ===== design/fhm_pkg.sv =====
// ----------------------------------------------------------------------------
// fhm_pkg
// Shared types and constants of the mutex with a FIFO wait queue.
// ----------------------------------------------------------------------------
package fhm_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 8;

   localparam int PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_FIELD_W = 8;
   localparam int WAIT_W     = 5;

   typedef logic [ID_WIDTH-1:0]   id_type;
   typedef logic [PTR_W-1:0]      ptr_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [ID_FIELD_W-1:0] id_field_type;
   typedef logic [WAIT_W-1:0]     wait_field_type;

   localparam ptr_type LAST_SLOT  = ptr_type'(QUEUE_DEPTH - 1);
   localparam cnt_type FULL_COUNT = cnt_type'(QUEUE_DEPTH);

   typedef enum logic {
      OP_LOCK   = 1'b0,
      OP_UNLOCK = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_GRANTED     = 3'd0,
      ST_QUEUED      = 3'd1,
      ST_FREED       = 3'd2,
      ST_HANDED      = 3'd3,
      ST_WRONG_OWNER = 3'd4,
      ST_NOT_LOCKED  = 3'd5,
      ST_QUEUE_FULL  = 3'd6
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      opcode_type   opcode;
      id_field_type requester_id;
   } req_payload_type;

   typedef struct packed {
      status_type     status;
      id_field_type   peer_id;
      logic           owner_valid;
      id_field_type   owner_id;
      wait_field_type waiting_count;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/fhm_if.sv =====
// ----------------------------------------------------------------------------
// fhm_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface fhm_req_if;
   import fhm_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface fhm_rsp_if;
   import fhm_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/fhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fhm_ctrl
// Sequencer that takes a request and hands it to the datapath for execution.
// ----------------------------------------------------------------------------
module fhm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output fhm_pkg::dp_cmd_type    cmd,
   input  fhm_pkg::dp_status_type status
);
   import fhm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/fhm_dpath.sv =====
// ----------------------------------------------------------------------------
// fhm_dpath
// Owner register, wait queue memory with pointers, and response register.
// ----------------------------------------------------------------------------
module fhm_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  fhm_pkg::dp_cmd_type      cmd,
   output fhm_pkg::dp_status_type   status,
   input  fhm_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output fhm_pkg::rsp_payload_type rsp_payload
);
   import fhm_pkg::*;

   function automatic ptr_type next_ptr(input ptr_type p);
      return (p == LAST_SLOT) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   id_type          queue_mem [QUEUE_DEPTH];

   opcode_type      op_ff;
   id_type          who_ff;
   id_type          head_data_ff;

   logic            holder_valid_ff;
   logic            holder_valid_in;
   id_type          holder_id_ff;
   id_type          holder_id_in;
   ptr_type         head_ff;
   ptr_type         head_in;
   ptr_type         tail_ff;
   ptr_type         tail_in;
   cnt_type         count_ff;
   cnt_type         count_in;
   logic            mem_we;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   status_type      code;
   id_type          peer;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_payload.opcode;
         who_ff <= id_type'(req_payload.requester_id);
      end
   end

   always_ff @(posedge clock) begin
      head_data_ff <= queue_mem[head_ff];
      if (cmd.execute && mem_we) begin
         queue_mem[tail_ff] <= who_ff;
      end
   end

   always_comb begin
      holder_valid_in = holder_valid_ff;
      holder_id_in    = holder_id_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      mem_we          = 1'b0;
      peer            = '0;
      code            = ST_NOT_LOCKED;
      case (op_ff)
         OP_LOCK: begin
            if (!holder_valid_ff) begin
               holder_valid_in = 1'b1;
               holder_id_in    = who_ff;
               code            = ST_GRANTED;
            end else if (count_ff >= FULL_COUNT) begin
               code = ST_QUEUE_FULL;
            end else begin
               peer     = holder_id_ff;
               mem_we   = 1'b1;
               tail_in  = next_ptr(tail_ff);
               count_in = cnt_type'(count_ff + 1'b1);
               code     = ST_QUEUED;
            end
         end
         OP_UNLOCK: begin
            if (!holder_valid_ff) begin
               code = ST_NOT_LOCKED;
            end else if (holder_id_ff != who_ff) begin
               peer = holder_id_ff;
               code = ST_WRONG_OWNER;
            end else if (count_ff != '0) begin
               holder_id_in = head_data_ff;
               head_in      = next_ptr(head_ff);
               count_in     = cnt_type'(count_ff - 1'b1);
               peer         = head_data_ff;
               code         = ST_HANDED;
            end else begin
               holder_valid_in = 1'b0;
               holder_id_in    = '0;
               code            = ST_FREED;
            end
         end
         default: begin
            code = ST_NOT_LOCKED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holder_valid_ff <= 1'b0;
         holder_id_ff    <= '0;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
      end else if (cmd.execute) begin
         holder_valid_ff <= holder_valid_in;
         holder_id_ff    <= holder_id_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         count_ff        <= count_in;
      end
   end

   always_comb begin
      rsp_data_in.status        = code;
      rsp_data_in.peer_id       = id_field_type'(peer);
      rsp_data_in.owner_valid   = holder_valid_in;
      rsp_data_in.owner_id      = holder_valid_in ? id_field_type'(holder_id_in) : '0;
      rsp_data_in.waiting_count = wait_field_type'(count_in);
      rsp_valid_in              = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_data_ff;

endmodule

// ===== design/fifo_handoff_mutex_unit.sv =====
// ----------------------------------------------------------------------------
// fifo_handoff_mutex_unit
// Hardware mutex with a FIFO queue of waiting requesters.
//
//   Channel   Direction  Handshake      Payload
//   req_ch    in         valid/ready    opcode, requester_id
//   rsp_ch    out        valid/ready    status, peer_id, owner_valid,
//                                       owner_id, waiting_count
//
// Each request passes the two-state sequencer: the idle state accepts it while
// the registered read port of the queue memory reads the queue head, and the
// execute state executes it into the response register once that is free.
// Synchronous reset frees the mutex and empties the queue; queue contents
// are not cleared. A response that is not taken holds the next request in
// execution, while that request can still be accepted.
// ----------------------------------------------------------------------------
module fifo_handoff_mutex_unit (
   input  logic      clock,
   input  logic      reset,
   fhm_req_if.sink   req_ch,
   fhm_rsp_if.source rsp_ch
);
   import fhm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   fhm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   fhm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_ch.payload),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_payload (rsp_ch.payload)
   );

endmodule

// ===== design/fhm_checker.sv =====
// ----------------------------------------------------------------------------
// fhm_checker
// Port-level checks on the mutex responses.
// ----------------------------------------------------------------------------
module fhm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input fhm_pkg::rsp_payload_type rsp_payload
);
   import fhm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Stalled response changed.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response present after reset.");

   a_freed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_FREED |->
         !rsp_payload.owner_valid && rsp_payload.owner_id == '0 &&
         rsp_payload.waiting_count == '0)
      else $error("Freed mutex still shows an owner or waiters.");

   a_queued: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_QUEUED |->
         rsp_payload.owner_valid && rsp_payload.peer_id == rsp_payload.owner_id &&
         rsp_payload.waiting_count != '0)
      else $error("Queued transfer inconsistent with owner state.");

   a_handed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_HANDED |->
         rsp_payload.owner_valid && rsp_payload.peer_id == rsp_payload.owner_id)
      else $error("Hand-over did not pass ownership to the new owner.");

endmodule

bind fifo_handoff_mutex_unit fhm_checker u_fhm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

// ===== tb/fifo_handoff_mutex_unit_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_handoff_mutex_unit_tb
// Checks the mutex with its FIFO wait queue against a behavioral mirror of
// the owner and the waiters. Directed tests cover grant, free, hand-over,
// refused unlocks, an owner that locks again and a full queue. Random traffic
// then follows, built mostly from lock and owner-unlock sequences. The
// request side sends in bursts, with gaps except in one random phase, and
// the response side stalls in patterns of its own.
// ----------------------------------------------------------------------------
module fifo_handoff_mutex_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fhm_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fhm_req_if req_ch ();
   fhm_rsp_if rsp_ch ();

   fifo_handoff_mutex_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic            held;
   id_type          holder;
   id_type          waiters [QUEUE_DEPTH];
   int              head;
   int              tail;
   int              waiting;
   rsp_payload_type expected_rsps [$];

   int error_count = 0;
   int idle_cycles = 0;
   int burst_left  = 0;
   bit gaps_enabled = 1'b1;
   int ready_mode  = 0;
   int ready_left  = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic rsp_payload_type predict_response(req_payload_type req);
      rsp_payload_type rsp;
      id_type          who;
      who = id_type'(req.requester_id);
      rsp = '0;
      if (req.opcode == OP_LOCK) begin
         if (!held) begin
            held       = 1'b1;
            holder     = who;
            rsp.status = ST_GRANTED;
         end else if (waiting >= QUEUE_DEPTH) begin
            rsp.status = ST_QUEUE_FULL;
         end else begin
            rsp.peer_id   = id_field_type'(holder);
            waiters[tail] = who;
            tail          = (tail + 1) % QUEUE_DEPTH;
            waiting++;
            rsp.status    = ST_QUEUED;
         end
      end else begin
         if (!held) begin
            rsp.status = ST_NOT_LOCKED;
         end else if (holder != who) begin
            rsp.peer_id = id_field_type'(holder);
            rsp.status  = ST_WRONG_OWNER;
         end else if (waiting > 0) begin
            holder      = waiters[head];
            head        = (head + 1) % QUEUE_DEPTH;
            waiting--;
            rsp.peer_id = id_field_type'(holder);
            rsp.status  = ST_HANDED;
         end else begin
            held       = 1'b0;
            holder     = '0;
            rsp.status = ST_FREED;
         end
      end
      rsp.owner_valid   = held;
      rsp.owner_id      = held ? id_field_type'(holder) : '0;
      rsp.waiting_count = wait_field_type'(waiting);
      return rsp;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: mismatch on %s, got %0d, expected %0d", $realtime, field, got, want);
      end
   endtask

   task automatic send_request(opcode_type op, id_field_type id);
      int              gap;
      req_payload_type req;
      if (burst_left == 0) begin
         gap = gaps_enabled ? $urandom_range(1, 8) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req.opcode       = op;
      req.requester_id = id;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= req;
      do @(posedge clock); while (!req_ch.ready);
      expected_rsps.push_back(predict_response(req_ch.payload));
   endtask

   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() != 0);
   endtask

   task automatic test_grant_and_free();
      send_request(OP_LOCK, 8'h00);
      send_request(OP_UNLOCK, 8'h00);
   endtask

   task automatic test_refusals_and_requeue();
      send_request(OP_UNLOCK, 8'h5A);
      send_request(OP_LOCK, 8'hFF);
      send_request(OP_UNLOCK, 8'h00);
      send_request(OP_LOCK, 8'hFF);
      send_request(OP_UNLOCK, 8'hFF);
   endtask

   task automatic test_queue_overflow();
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_request(OP_LOCK, id_field_type'(i * 17));
      end
      send_request(OP_LOCK, 8'hA5);
   endtask

   task automatic test_random_traffic(int count, int lock_pct, bit use_gaps);
      int kind;
      gaps_enabled = use_gaps;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 80) begin
            if (!held || $urandom_range(0, 99) < lock_pct) begin
               send_request(OP_LOCK, id_field_type'($urandom_range(0, 255)));
            end else begin
               send_request(OP_UNLOCK, id_field_type'(holder));
            end
         end else if (kind < 90) begin
            send_request(OP_UNLOCK, id_field_type'($urandom_range(0, 255)));
         end else begin
            send_request(OP_LOCK, id_field_type'($urandom_range(0, 255)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_left = 0;
      end else begin
         if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(4, 40);
         end else begin
            ready_left--;
         end
         case (ready_mode)
            0: begin
               rsp_ch.ready <= 1'b1;
            end
            1: begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_ch.ready <= (ready_left % 8 == 0);
            end
            default: begin
               rsp_ch.ready <= ready_left[0];
            end
         endcase
      end
   end

   always @(posedge clock) begin : response_check
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response status", int'(got.status), -1);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (got.peer_id !== want.peer_id)
                  report_mismatch("peer_id", int'(got.peer_id), int'(want.peer_id));
               if (got.owner_valid !== want.owner_valid)
                  report_mismatch("owner_valid", int'(got.owner_valid),
                                  int'(want.owner_valid));
               if (got.owner_id !== want.owner_id)
                  report_mismatch("owner_id", int'(got.owner_id), int'(want.owner_id));
               if (got.waiting_count !== want.waiting_count)
                  report_mismatch("waiting_count", int'(got.waiting_count),
                                  int'(want.waiting_count));
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < IDLE_LIMIT);
      $display("fifo_handoff_mutex_unit_tb NOT OK");
      $finish;
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      held    = 1'b0;
      holder  = '0;
      head    = 0;
      tail    = 0;
      waiting = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_grant_and_free();
      test_refusals_and_requeue();
      test_queue_overflow();
      test_random_traffic(300, 50, 1'b1);
      wait_until_drained();
      test_random_traffic(250, 70, 1'b0);
      wait_until_drained();
      test_random_traffic(300, 25, 1'b1);
      wait_until_drained();
      test_random_traffic(200, 55, 1'b1);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("fifo_handoff_mutex_unit_tb OK");
      end else begin
         $display("fifo_handoff_mutex_unit_tb NOT OK");
      end
      $finish;
   end

endmodule
